### rtl/core/ssd_pkg.sv
`timescale 1ns / 1ps

package ssd_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned POSITIONS   = 4;

  localparam logic [3:0] LAST_SLOT = 4'd8;
  localparam logic [1:0] LAST_POS  = 2'd3;

  localparam logic       OP_TIME = 1'b0;
  localparam logic       OP_BYTE = 1'b1;

  localparam logic [7:0] PAT_BLANK = 8'hFF;
  localparam logic [7:0] LETTER_A  = 8'h41;
  localparam logic [7:0] LETTER_D  = 8'h64;
  localparam logic [7:0] PAT_A     = 8'h88;
  localparam logic [7:0] PAT_D     = 8'hA1;

  // One decoded request: active-low pattern per position, dot folded into bit 7.
  typedef struct packed {
    logic [POSITIONS-1:0][7:0] pat;
  } ssd_pats_t;

  function automatic logic [7:0] bcd_font(input logic [3:0] d);
    logic [7:0] p;
    case (d)
      4'd0:    p = 8'hC0;
      4'd1:    p = 8'hF9;
      4'd2:    p = 8'hA4;
      4'd3:    p = 8'hB0;
      4'd4:    p = 8'h99;
      4'd5:    p = 8'h92;
      4'd6:    p = 8'h82;
      4'd7:    p = 8'hF8;
      4'd8:    p = 8'h80;
      4'd9:    p = 8'h90;
      default: p = PAT_BLANK;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] letter_font(input logic [7:0] c);
    logic [7:0] p;
    case (c)
      LETTER_A: p = PAT_A;
      LETTER_D: p = PAT_D;
      default:  p = PAT_BLANK;
    endcase
    return p;
  endfunction

endpackage

### rtl/core/ssd_front.sv
`timescale 1ns / 1ps

module ssd_front
  import ssd_pkg::*;
(
  input  logic       opcode,
  input  logic [3:0] hours_tens,
  input  logic [3:0] hours_units,
  input  logic [3:0] minutes_tens,
  input  logic [3:0] minutes_units,
  input  logic       seconds_dot,
  input  logic [7:0] byte_value,
  input  logic [7:0] mark_letter,
  output ssd_pats_t  pats
);

  logic [1:0]  hund;
  logic [6:0]  rem;
  logic [14:0] prod;
  logic [3:0]  tens;
  logic [6:0]  units_w;
  logic [7:0]  hu_pat;

  // byte split: hundreds by compare, tens by x205 >> 11 (exact below 100)
  always_comb begin
    if (byte_value >= 8'd200) begin
      hund = 2'd2;
      rem  = 7'(byte_value - 8'd200);
    end else if (byte_value >= 8'd100) begin
      hund = 2'd1;
      rem  = 7'(byte_value - 8'd100);
    end else begin
      hund = 2'd0;
      rem  = byte_value[6:0];
    end
    prod    = 15'(rem) * 15'd205;
    tens    = prod[14:11];
    units_w = 7'(rem - 7'(tens) * 7'd10);
  end

  always_comb begin
    hu_pat = bcd_font(hours_units);
    if (seconds_dot) begin
      hu_pat[7] = 1'b0;
    end
    if (opcode == OP_TIME) begin
      pats.pat[0] = bcd_font(minutes_units);
      pats.pat[1] = bcd_font(minutes_tens);
      pats.pat[2] = hu_pat;
      pats.pat[3] = (hours_tens == 4'd0) ? PAT_BLANK : bcd_font(hours_tens);
    end else begin
      pats.pat[0] = bcd_font(units_w[3:0]);
      pats.pat[1] = bcd_font(tens);
      pats.pat[2] = bcd_font({2'b00, hund});
      pats.pat[3] = letter_font(mark_letter);
    end
  end

endmodule

### rtl/core/ssd_queue.sv
`timescale 1ns / 1ps

module ssd_queue
  import ssd_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  ssd_pats_t push_data,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output ssd_pats_t head_data
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_MAX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);

  ssd_pats_t       mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign full       = (count_r == CNT_MAX);
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_MAX) ? '0 : PW'(wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_MAX) ? '0 : PW'(rd_ptr_r + 1'b1);
    end
    if (push && !pop) begin
      count_nxt = CW'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = CW'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full && !pop |-> !push) else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid) else $error("queue underflow");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX) else $error("queue count out of range");

endmodule

### rtl/core/ssd_back.sv
`timescale 1ns / 1ps

module ssd_back
  import ssd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       common_active_high,
  input  logic       head_valid,
  input  ssd_pats_t  head_data,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] digit_select,
  output logic [7:0] segment_drive,
  output logic       last_slot
);

  logic [1:0] pos_r, pos_nxt;
  logic [3:0] slot_r, slot_nxt;
  logic       ov_r, ov_nxt;
  logic [3:0] sel_r, sel_nxt;
  logic [7:0] seg_r, seg_nxt;
  logic       last_r, last_nxt;
  logic       load;
  logic       pos_done;
  logic [7:0] cur_pat;

  assign load     = head_valid && (!ov_r || out_ready);
  assign pos_done = (slot_r == LAST_SLOT);
  assign pop      = load && pos_done && (pos_r == LAST_POS);
  assign cur_pat  = head_data.pat[pos_r];

  always_comb begin
    pos_nxt  = pos_r;
    slot_nxt = slot_r;
    ov_nxt   = ov_r && !out_ready;
    sel_nxt  = sel_r;
    seg_nxt  = seg_r;
    last_nxt = last_r;
    if (load) begin
      ov_nxt  = 1'b1;
      sel_nxt = 4'b1000 >> pos_r;
      if (!common_active_high) begin
        sel_nxt = ~sel_nxt;
      end
      // slots 0..7 strobe one segment (bit 7 is the dot); slot 8 is dark
      seg_nxt  = pos_done ? PAT_BLANK : (~(8'h01 << slot_r[2:0]) | cur_pat);
      last_nxt = pop;
      if (pos_done) begin
        slot_nxt = '0;
        pos_nxt  = 2'(pos_r + 1'b1);
      end else begin
        slot_nxt = 4'(slot_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      slot_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      slot_r <= slot_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_r  <= sel_nxt;
    seg_r  <= seg_nxt;
    last_r <= last_nxt;
  end

  assign out_valid     = ov_r;
  assign digit_select  = sel_r;
  assign segment_drive = seg_r;
  assign last_slot     = last_r;

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= LAST_SLOT) else $error("slot counter out of range");

  a_sel_shape: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> ($onehot(sel_r) || $onehot(~sel_r))) else $error("bad digit select");

  a_last_dark: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && last_r |-> seg_r == PAT_BLANK) else $error("last slot not blank");

  a_frame_align: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (pos_r == 2'd0 && slot_r == 4'd0)) else $error("frame misaligned");

endmodule

### rtl/core/seven_segment_scan_driver.sv
`timescale 1ns / 1ps
// channel | dir | handshake             | payload
// in_     | in  | in_tvalid/in_tready   | in_tuser opcode, in_tdata[32:0] display request
// out_    | out | out_tvalid/out_tready | out_tdata[11:0] drive slot, out_tlast
// cfg_    | in  | cfg_valid/cfg_ready   | cfg_data common polarity
//
// Each request produces 36 slots, one per cycle while out_tready is high;
// the slot scanner pops the request from the queue as its last slot loads.
// A request is decoded on entry and queued (QUEUE_DEPTH deep); input stalls
// only when the queue is full. Output holds while out_tready is low.
// Reset is synchronous; polarity resets to common low.

module seven_segment_scan_driver
  import ssd_pkg::*;
#(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // opcode
  input  logic        in_tuser,
  // hours_tens, hours_units, minutes_tens, minutes_units,
  // seconds_dot, byte_value, mark_letter
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // digit_select, segment_drive
  output logic [15:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  logic      cah_r, cah_nxt;
  ssd_pats_t dec_pats;
  ssd_pats_t head_data;
  logic      q_full, head_valid, pop, push;
  logic [3:0] sel;
  logic [7:0] seg;

  assign cfg_ready = 1'b1;
  assign cah_nxt   = (cfg_valid && cfg_ready) ? cfg_data : cah_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cah_r <= 1'b0;
    end else begin
      cah_r <= cah_nxt;
    end
  end

  assign in_tready = !q_full;
  assign push      = in_tvalid && in_tready;

  ssd_front u_front (
    .opcode        (in_tuser),
    .hours_tens    (in_tdata[3:0]),
    .hours_units   (in_tdata[7:4]),
    .minutes_tens  (in_tdata[11:8]),
    .minutes_units (in_tdata[15:12]),
    .seconds_dot   (in_tdata[16]),
    .byte_value    (in_tdata[24:17]),
    .mark_letter   (in_tdata[32:25]),
    .pats          (dec_pats)
  );

  ssd_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (dec_pats),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  ssd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .common_active_high (cah_r),
    .head_valid         (head_valid),
    .head_data          (head_data),
    .pop                (pop),
    .out_valid          (out_tvalid),
    .out_ready          (out_tready),
    .digit_select       (sel),
    .segment_drive      (seg),
    .last_slot          (out_tlast)
  );

  assign out_tdata = {4'b0000, seg, sel};

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ssd_pkg::*;

  localparam int unsigned SLOTS_PER_POS = 9;
  localparam int unsigned RAND_ITEMS    = 400;
  localparam int unsigned IDLE_LIMIT    = 2000;

  typedef struct packed {
    logic [3:0] sel;
    logic [7:0] seg;
    logic       last;
  } drive_slot_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic        in_tuser;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;

  logic [40:0] pending_reqs[$];
  drive_slot_t slots_due[$];

  logic        polarity_shadow;
  logic        req_taken;
  int          cfg_writes;
  int          errors;
  int          idle_cycles;

  // driver pacing
  int          burst_left;
  int          gap_left;
  // receiver pacing
  int          rx_mode;
  int          rx_mode_left;
  int          rx_stall_left;

  logic [7:0]  digit_font [10] = '{8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99,
                                   8'h92, 8'h82, 8'hF8, 8'h80, 8'h90};

  seven_segment_scan_driver DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // opcode (tuser) at bit 0, then hours_tens, hours_units, minutes_tens,
  // minutes_units, seconds_dot, byte_value, mark_letter (tdata from bit 0 up)
  function automatic logic [40:0] pack_req(input logic op, input logic [3:0] ht,
                                           input logic [3:0] hu, input logic [3:0] mt,
                                           input logic [3:0] mu, input logic dot,
                                           input logic [7:0] bv, input logic [7:0] ml);
    return {7'd0, ml, bv, dot, mu, mt, hu, ht, op};
  endfunction

  function automatic logic [7:0] bcd_seg(input logic [3:0] d);
    return (d > 4'd9) ? PAT_BLANK : digit_font[d];
  endfunction

  // Expands one request into its 36 drive slots.
  function automatic void predict_scan(input logic [40:0] d, input logic pol);
    logic [7:0] pat [4];
    logic       dot [4];
    logic [7:0] val;
    logic [7:0] ml;
    logic [3:0] sel;
    logic [7:0] seg;
    drive_slot_t sl;
    int k;
    val = d[25:18];
    ml  = d[33:26];
    for (int p = 0; p < 4; p++) dot[p] = 1'b0;
    if (d[0] == OP_TIME) begin
      pat[0] = bcd_seg(d[16:13]);
      pat[1] = bcd_seg(d[12:9]);
      pat[2] = bcd_seg(d[8:5]);
      pat[3] = (d[4:1] == 4'd0) ? PAT_BLANK : bcd_seg(d[4:1]);
      dot[2] = d[17];
    end else begin
      pat[0] = digit_font[val % 10];
      pat[1] = digit_font[(val / 10) % 10];
      pat[2] = digit_font[val / 100];
      if (ml == LETTER_A)      pat[3] = PAT_A;
      else if (ml == LETTER_D) pat[3] = PAT_D;
      else                     pat[3] = PAT_BLANK;
    end
    k = 0;
    for (int p = 0; p < 4; p++) begin
      sel = 4'b0001 << (3 - p);
      if (!pol) sel = ~sel;
      for (int s = 0; s < SLOTS_PER_POS; s++) begin
        if (s < 7)       seg = ~(8'b1 << s) | pat[p];
        else if (s == 7) seg = dot[p] ? 8'h7F : PAT_BLANK;
        else             seg = PAT_BLANK;
        sl.sel  = sel;
        sl.seg  = seg;
        sl.last = (k == 4 * SLOTS_PER_POS - 1);
        slots_due.push_back(sl);
        k++;
      end
    end
  endfunction

  task automatic write_polarity(input logic v);
    int n0;
    n0 = cfg_writes;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(negedge clk); while (cfg_writes == n0);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain;
    while (pending_reqs.size() != 0 || in_tvalid || slots_due.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic queue_random(input int n);
    logic [3:0] dg [4];
    logic [7:0] ml;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < 4; j++)
        dg[j] = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(0, 9));
      case ($urandom_range(0, 3))
        0:       ml = LETTER_A;
        1:       ml = LETTER_D;
        default: ml = 8'($urandom_range(0, 255));
      endcase
      pending_reqs.push_back(pack_req(1'($urandom_range(0, 1)), dg[0], dg[1], dg[2],
                                      dg[3], 1'($urandom_range(0, 1)),
                                      8'($urandom_range(0, 255)), ml));
    end
  endtask

  // Stimulus sequencing: polarity changes only once the scanner has drained.
  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tuser   = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // reset polarity (common low), directed requests
    pending_reqs.push_back(pack_req(OP_TIME, 4'd0, 4'd0, 4'd0, 4'd0, 1'b0, 8'd0, 8'd0));
    pending_reqs.push_back(pack_req(OP_TIME, 4'd1, 4'd9, 4'd5, 4'd9, 1'b1, 8'hFF, LETTER_A));
    pending_reqs.push_back(pack_req(OP_TIME, 4'd2, 4'd3, 4'd4, 4'd8, 1'b1, 8'h00, 8'hFF));
    pending_reqs.push_back(pack_req(OP_TIME, 4'd9, 4'd8, 4'd7, 4'd6, 1'b0, 8'h55, 8'h00));
    pending_reqs.push_back(pack_req(OP_TIME, 4'd10, 4'd11, 4'd12, 4'd13, 1'b1, 8'd0, 8'd0));
    pending_reqs.push_back(pack_req(OP_TIME, 4'd15, 4'd15, 4'd15, 4'd15, 1'b1, 8'hFF, 8'hFF));
    pending_reqs.push_back(pack_req(OP_TIME, 4'd14, 4'd0, 4'd1, 4'd2, 1'b0, 8'd0, 8'd0));
    pending_reqs.push_back(pack_req(OP_TIME, 4'd0, 4'd12, 4'd9, 4'd15, 1'b1, 8'd0, 8'd0));
    pending_reqs.push_back(pack_req(OP_BYTE, 4'd0, 4'd0, 4'd0, 4'd0, 1'b0, 8'd0, LETTER_A));
    pending_reqs.push_back(pack_req(OP_BYTE, 4'd0, 4'd0, 4'd0, 4'd0, 1'b0, 8'd255, LETTER_D));
    pending_reqs.push_back(pack_req(OP_BYTE, 4'd15, 4'd15, 4'd15, 4'd15, 1'b1, 8'd100,
                                    8'h61));
    pending_reqs.push_back(pack_req(OP_BYTE, 4'd9, 4'd9, 4'd9, 4'd9, 1'b1, 8'd9, 8'h44));
    pending_reqs.push_back(pack_req(OP_BYTE, 4'd0, 4'd0, 4'd0, 4'd0, 1'b0, 8'd99, 8'h00));
    pending_reqs.push_back(pack_req(OP_BYTE, 4'd0, 4'd0, 4'd0, 4'd0, 1'b0, 8'd199, 8'hFF));
    pending_reqs.push_back(pack_req(OP_BYTE, 4'd0, 4'd0, 4'd0, 4'd0, 1'b1, 8'd10, 8'h40));
    pending_reqs.push_back(pack_req(OP_BYTE, 4'd0, 4'd0, 4'd0, 4'd0, 1'b0, 8'd128, 8'h42));
    pending_reqs.push_back(pack_req(OP_BYTE, 4'd0, 4'd0, 4'd0, 4'd0, 1'b0, 8'd200, 8'h65));
    pending_reqs.push_back(pack_req(OP_BYTE, 4'd0, 4'd0, 4'd0, 4'd0, 1'b0, 8'd1, 8'hC1));
    drain();

    write_polarity(1'b1);
    pending_reqs.push_back(pack_req(OP_TIME, 4'd0, 4'd8, 4'd8, 4'd8, 1'b1, 8'd0, 8'd0));
    pending_reqs.push_back(pack_req(OP_BYTE, 4'd0, 4'd0, 4'd0, 4'd0, 1'b0, 8'd255, LETTER_A));
    queue_random(RAND_ITEMS / 3);
    drain();

    write_polarity(1'b0);
    queue_random(RAND_ITEMS / 3);
    drain();

    write_polarity(1'b1);
    queue_random(RAND_ITEMS - 2 * (RAND_ITEMS / 3));
    drain();

    repeat (40) @(negedge clk);
    if (slots_due.size() != 0) errors++;
    if (errors == 0) begin
      $display("seven_segment_scan_driver verification clean");
    end else begin
      $display("seven_segment_scan_driver verification failed");
    end
    $finish;
  end

  // Request driver: bursts of back-to-back requests separated by random gaps.
  always @(negedge clk) begin
    logic        nv;
    logic [40:0] nd;
    nv = in_tvalid;
    nd = {in_tdata, in_tuser};
    if (rst_n && !(in_tvalid && !req_taken)) begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_reqs.size() != 0) begin
        nv = 1'b1;
        nd = pending_reqs.pop_front();
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 50);
        end
      end
    end
    in_tvalid <= nv;
    in_tuser  <= nd[0];
    in_tdata  <= nd[40:1];
  end

  // Result receiver stall pattern, switching style every so often.
  always @(negedge clk) begin
    logic nr;
    if (rx_mode_left <= 0) begin
      rx_mode      = $urandom_range(0, 3);
      rx_mode_left = $urandom_range(50, 300);
    end
    rx_mode_left--;
    case (rx_mode)
      0: nr = 1'b1;
      1: nr = $urandom_range(0, 1);
      2: begin
        if (rx_stall_left > 0) begin
          rx_stall_left--;
          nr = 1'b0;
        end else begin
          nr = 1'b1;
          if ($urandom_range(0, 15) == 0) rx_stall_left = $urandom_range(1, 12);
        end
      end
      default: nr = ($urandom_range(0, 4) != 0);
    endcase
    out_tready <= rst_n ? nr : 1'b0;
  end

  // Monitor: predicts on accepted requests, checks accepted slots, watchdog.
  always @(posedge clk) begin
    drive_slot_t got;
    drive_slot_t want;
    logic        any_hs;
    any_hs = 1'b0;
    if (!rst_n) begin
      req_taken       <= 1'b0;
      polarity_shadow <= 1'b0;
      idle_cycles     <= 0;
    end else begin
      req_taken <= in_tvalid && in_tready;
      if (cfg_valid && cfg_ready) begin
        polarity_shadow <= cfg_data;
        cfg_writes      <= cfg_writes + 1;
        any_hs = 1'b1;
      end
      if (in_tvalid && in_tready) begin
        predict_scan({in_tdata, in_tuser}, polarity_shadow);
        any_hs = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        any_hs   = 1'b1;
        got.sel  = out_tdata[3:0];
        got.seg  = out_tdata[11:4];
        got.last = out_tlast;
        if (slots_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected slot: sel=%h seg=%h last=%b", got.sel, got.seg, got.last);
        end else begin
          want = slots_due.pop_front();
          if (got != want) begin
            errors++;
            if (errors <= 10)
              $display("slot mismatch: sel exp=%h act=%h seg exp=%h act=%h last exp=%b act=%b",
                       want.sel, got.sel, want.seg, got.seg, want.last, got.last);
          end
        end
      end
      if (any_hs) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("seven_segment_scan_driver verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    errors        = 0;
    cfg_writes    = 0;
    burst_left    = 0;
    gap_left      = 0;
    rx_mode       = 0;
    rx_mode_left  = 0;
    rx_stall_left = 0;
  end

endmodule
